>>> design/iamp_pkg.sv
`default_nettype none

package iamp_pkg;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [9:0]  OCTET_MAX   = 10'd255;
	localparam logic [13:0] OCTET_SAT   = 14'd1023;
	localparam logic [9:0]  PREFIX_SAT  = 10'd63;
	localparam logic [5:0]  PREFIX_FULL = 6'd32;
	localparam logic [4:0]  COUNT_SAT   = 5'd31;
	localparam logic [2:0]  OCTET_LAST  = 3'd3;
	localparam logic [2:0]  OCTET_COUNT = 3'd4;

	// Progress through one dotted quad, together with the word being built.
	typedef struct packed {
		logic [2:0]  idx;
		logic [2:0]  dcnt;
		logic [9:0]  acc;
		logic [31:0] word;
		logic        err;
	} oct_t;

	typedef struct packed {
		logic        valid_res;
		logic [31:0] address;
		logic [31:0] mask;
	} res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic oct_t oct_store(input oct_t s);
		oct_t r;
		r = s;
		if ((s.acc > OCTET_MAX) || (s.idx > OCTET_LAST)) begin
			r.err = 1'b1;
		end else begin
			unique case (s.idx[1:0])
				2'd0: r.word[31:24] = s.word[31:24] | s.acc[7:0];
				2'd1: r.word[23:16] = s.word[23:16] | s.acc[7:0];
				2'd2: r.word[15:8]  = s.word[15:8]  | s.acc[7:0];
				default: r.word[7:0] = s.word[7:0] | s.acc[7:0];
			endcase
			r.idx = s.idx + 3'd1;
		end
		r.dcnt = 3'd0;
		r.acc  = 10'd0;
		return r;
	endfunction

	function automatic oct_t oct_char(input oct_t s, input logic [7:0] c);
		oct_t        r;
		logic [13:0] v;
		r = s;
		v = 14'(s.acc) * 14'd10 + {10'b0, c[3:0]};
		if (s.err) begin
			r = s;
		end else if ((s.idx > OCTET_LAST) || (s.dcnt > OCTET_LAST)) begin
			r.err = 1'b1;
		end else if (c != CH_DOT) begin
			if (is_digit(c)) begin
				r.acc = (v > OCTET_SAT) ? OCTET_SAT[9:0] : v[9:0];
			end else begin
				r.err = 1'b1;
			end
			r.dcnt = s.dcnt + 3'd1;
		end else begin
			r = oct_store(s);
		end
		return r;
	endfunction

	// A pending octet is stored, and fewer than four octets is an error.
	function automatic oct_t oct_end(input oct_t s);
		oct_t r;
		r = s;
		if (!r.err && (r.dcnt != 3'd0)) begin
			r = oct_store(r);
		end
		if (!r.err && (r.idx < OCTET_COUNT)) begin
			r.err = 1'b1;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/iamp_parse.sv
`default_nettype none

module iamp_parse import iamp_pkg::*; #(
	parameter logic [4:0] ADDR_MAX = 5'd15,
	parameter logic [4:0] MASK_MAX = 5'd31
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire logic [7:0] ch,
	input  wire logic       last,
	output res_t            res
);

	logic        in_mask_q;
	logic [2:0]  idx_q;
	logic [2:0]  dcnt_q;
	logic [9:0]  acc_q;
	logic [31:0] addr_word_q;
	logic [31:0] mask_word_q;
	logic [4:0]  acnt_q;
	logic [4:0]  mcnt_q;
	logic        has_dot_q;
	logic [5:0]  pacc_q;
	logic        aerr_q;
	logic        derr_q;
	logic        perr_q;

	oct_t        a_cur;
	oct_t        m_cur;
	oct_t        a_nx;
	oct_t        m_nx;
	oct_t        a_fin;
	oct_t        m_fin;
	logic        in_mask_nx;
	logic [4:0]  acnt_nx;
	logic [4:0]  mcnt_nx;
	logic        has_dot_nx;
	logic [5:0]  pacc_nx;
	logic        perr_nx;
	logic [9:0]  pv;
	logic        ok;
	logic [31:0] mask_val;

	always_comb begin
		a_cur = '{idx: idx_q, dcnt: dcnt_q, acc: acc_q, word: addr_word_q, err: aerr_q};
		m_cur = '{idx: idx_q, dcnt: dcnt_q, acc: acc_q, word: mask_word_q, err: derr_q};
		a_nx       = a_cur;
		m_nx       = m_cur;
		in_mask_nx = in_mask_q;
		acnt_nx    = acnt_q;
		mcnt_nx    = mcnt_q;
		has_dot_nx = has_dot_q;
		pacc_nx    = pacc_q;
		perr_nx    = perr_q;
		pv         = 10'(pacc_q) * 10'd10 + {6'b0, ch[3:0]};

		if (!in_mask_q) begin
			if (ch == CH_SLASH) begin
				if (acnt_q > ADDR_MAX) begin
					a_nx.err = 1'b1;
				end
				a_nx = oct_end(a_nx);
				// The shared octet counters start afresh for the mask.
				m_nx.idx  = 3'd0;
				m_nx.dcnt = 3'd0;
				m_nx.acc  = 10'd0;
				in_mask_nx = 1'b1;
			end else begin
				if (acnt_q < COUNT_SAT) begin
					acnt_nx = acnt_q + 5'd1;
				end
				a_nx = oct_char(a_cur, ch);
				m_nx.idx  = a_nx.idx;
				m_nx.dcnt = a_nx.dcnt;
				m_nx.acc  = a_nx.acc;
			end
		end else if (mcnt_q < MASK_MAX) begin
			mcnt_nx = mcnt_q + 5'd1;
			if (ch == CH_DOT) begin
				has_dot_nx = 1'b1;
			end else if (is_digit(ch)) begin
				pacc_nx = (pv > PREFIX_SAT) ? PREFIX_SAT[5:0] : pv[5:0];
			end else begin
				perr_nx = 1'b1;
			end
			m_nx = oct_char(m_cur, ch);
		end

		a_fin = oct_end(a_nx);
		m_fin = oct_end(m_nx);
		mask_val = ~(32'hFFFF_FFFF >> pacc_nx);

		if (!in_mask_nx) begin
			ok = !a_fin.err;
			res.mask = 32'd0;
		end else if (has_dot_nx) begin
			ok = !a_nx.err && !m_fin.err;
			res.mask = m_fin.word;
		end else begin
			ok = !a_nx.err && !perr_nx && (pacc_nx <= PREFIX_FULL);
			res.mask = (pacc_nx > PREFIX_FULL) ? 32'd0 : mask_val;
		end
		res.valid_res = ok;
		res.address   = ok ? (in_mask_nx ? a_nx.word : a_fin.word) : 32'd0;
		if (!ok) begin
			res.mask = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_mask_q   <= 1'b0;
			idx_q       <= 3'd0;
			dcnt_q      <= 3'd0;
			acc_q       <= 10'd0;
			addr_word_q <= 32'd0;
			mask_word_q <= 32'd0;
			acnt_q      <= 5'd0;
			mcnt_q      <= 5'd0;
			has_dot_q   <= 1'b0;
			pacc_q      <= 6'd0;
			aerr_q      <= 1'b0;
			derr_q      <= 1'b0;
			perr_q      <= 1'b0;
		end else if (go && last) begin
			in_mask_q   <= 1'b0;
			idx_q       <= 3'd0;
			dcnt_q      <= 3'd0;
			acc_q       <= 10'd0;
			addr_word_q <= 32'd0;
			mask_word_q <= 32'd0;
			acnt_q      <= 5'd0;
			mcnt_q      <= 5'd0;
			has_dot_q   <= 1'b0;
			pacc_q      <= 6'd0;
			aerr_q      <= 1'b0;
			derr_q      <= 1'b0;
			perr_q      <= 1'b0;
		end else if (go) begin
			in_mask_q   <= in_mask_nx;
			idx_q       <= in_mask_q ? m_nx.idx  : m_nx.idx;
			dcnt_q      <= m_nx.dcnt;
			acc_q       <= m_nx.acc;
			addr_word_q <= a_nx.word;
			mask_word_q <= m_nx.word;
			acnt_q      <= acnt_nx;
			mcnt_q      <= mcnt_nx;
			has_dot_q   <= has_dot_nx;
			pacc_q      <= pacc_nx;
			aerr_q      <= a_nx.err;
			derr_q      <= m_nx.err;
			perr_q      <= perr_nx;
		end
	end

endmodule

`default_nettype wire

>>> design/ipv4_address_mask_parser_unit.sv
// IPv4 address and mask parser.
// An address string such as "10.1.2.3/24" or "10.1.2.3/255.255.0.0" enters one
// character per word on the item channel (ch, with last set on the final
// character). One result word per string leaves on the result channel: valid_res,
// address and mask, both zero when the string is malformed.
// Both channels use valid and stall; a word moves at a clock edge where valid is
// high and stall is low.
// A character is registered on entry and parsed from that register; once the final
// character is parsed, its result is registered and res_valid rises. One character is
// accepted every cycle while item_stall is low; the rate is set by the single parse
// stage, whose per-character update is a short add, compare and octet insert.
// The item channel stalls only when a final character is waiting to be parsed
// while the result register is full and the result channel is stalled; ordinary
// characters keep flowing. A stalled result holds its value.
// Reset clears all parse state and empties both registers.
`default_nettype none

module ipv4_address_mask_parser_unit import iamp_pkg::*; #(
	parameter int ADDR_PART_MAX = 15,
	parameter int MASK_PART_MAX = 31
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output      logic        item_stall,
	input  wire logic [7:0]  ch,
	input  wire logic        last,
	output      logic        res_valid,
	input  wire logic        res_stall,
	output      logic        valid_res,
	output      logic [31:0] address,
	output      logic [31:0] mask
);

	localparam logic [4:0] ADDR_MAX = 5'(ADDR_PART_MAX);
	localparam logic [4:0] MASK_MAX = 5'(MASK_PART_MAX);

	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       go;
	res_t       res;
	logic       res_valid_q;
	res_t       res_q;

	assign item_stall = vld_s1 && last_s1 && res_valid_q && res_stall;
	assign go         = vld_s1 && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!item_stall) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	iamp_parse #(
		.ADDR_MAX(ADDR_MAX),
		.MASK_MAX(MASK_MAX)
	) u_parse (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.ch    (ch_s1),
		.last  (last_s1),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			res_q <= res;
		end
	end

	assign res_valid = res_valid_q;
	assign valid_res = res_q.valid_res;
	assign address   = res_q.address;
	assign mask      = res_q.mask;

endmodule

`default_nettype wire

>>> sim/ipv4_address_mask_parser_unit_test.sv
`timescale 1ns / 100ps

module ipv4_address_mask_parser_unit_test;
	import iamp_pkg::*;

	localparam int ADDR_LIMIT = 15;
	localparam int MASK_LIMIT = 31;
	localparam int unsigned QUAD_SAT = 1023;
	localparam int unsigned PFX_SAT = 63;
	localparam int unsigned HEAD_SAT = 31;
	localparam int unsigned OCTET_TOP = 255;
	localparam int unsigned PFX_TOP = 32;
	localparam int unsigned QUAD_LAST = 3;
	localparam int unsigned QUADS = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int CHARS_PER_PHASE = 115;

	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_SENDER_GAPS,
		FLOW_RECEIVER_STALLS,
		FLOW_BOTH
	} flow_t;

	typedef struct packed {
		logic [7:0] code;
		logic       final_char;
	} char_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [7:0]  ch = 8'h00;
	logic        last = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        valid_res;
	logic [31:0] address;
	logic [31:0] mask;

	ipv4_address_mask_parser_unit #(
		.ADDR_PART_MAX(ADDR_LIMIT),
		.MASK_PART_MAX(MASK_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.ch(ch),
		.last(last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.valid_res(valid_res),
		.address(address),
		.mask(mask)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	char_word_t  char_stream[$];
	res_t        due_results[$];
	logic [7:0]  draft[$];
	flow_t       flow = FLOW_FREE;
	logic        item_taken = 1'b0;
	int          mismatches = 0;
	int          chars_queued = 0;
	char_word_t  next_word;
	res_t        want;

	// Parser state, mirrored from the block's behaviour.
	logic        seen_slash;
	int unsigned quad_pos, quad_digits, quad_val;
	logic [31:0] addr_acc, mask_acc;
	int unsigned head_len, tail_len, pfx_val;
	logic        tail_dot, addr_bad, dot_bad, pfx_bad;

	function automatic void clear_parser();
		seen_slash = 1'b0;
		quad_pos = 0;
		quad_digits = 0;
		quad_val = 0;
		addr_acc = '0;
		mask_acc = '0;
		head_len = 0;
		tail_len = 0;
		pfx_val = 0;
		tail_dot = 1'b0;
		addr_bad = 1'b0;
		dot_bad = 1'b0;
		pfx_bad = 1'b0;
	endfunction

	function automatic logic is_num(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic void quad_store(inout logic [31:0] w, inout logic bad);
		if (quad_val > OCTET_TOP || quad_pos > QUAD_LAST) begin
			bad = 1'b1;
		end else begin
			w = w | (32'(quad_val) << (24 - 8 * quad_pos));
			quad_pos++;
		end
		quad_digits = 0;
		quad_val = 0;
	endfunction

	function automatic void quad_char(input logic [7:0] c, inout logic [31:0] w,
			inout logic bad);
		int unsigned v;
		if (!bad) begin
			if (quad_pos > QUAD_LAST || quad_digits > QUAD_LAST) begin
				bad = 1'b1;
			end else if (c != CH_DOT) begin
				if (is_num(c)) begin
					v = quad_val * 10 + int'(c - CH_ZERO);
					quad_val = (v > QUAD_SAT) ? QUAD_SAT : v;
				end else begin
					bad = 1'b1;
				end
				quad_digits++;
			end else begin
				quad_store(w, bad);
			end
		end
	endfunction

	function automatic void quad_end(inout logic [31:0] w, inout logic bad);
		if (!bad && quad_digits > 0)
			quad_store(w, bad);
		if (!bad && quad_pos < QUADS)
			bad = 1'b1;
	endfunction

	function automatic void parse_char(input logic [7:0] c, input logic fin);
		res_t        r;
		int unsigned v;
		if (!seen_slash) begin
			if (c == CH_SLASH) begin
				if (head_len > ADDR_LIMIT)
					addr_bad = 1'b1;
				quad_end(addr_acc, addr_bad);
				quad_pos = 0;
				quad_digits = 0;
				quad_val = 0;
				seen_slash = 1'b1;
			end else begin
				if (head_len < HEAD_SAT)
					head_len++;
				quad_char(c, addr_acc, addr_bad);
			end
		end else if (tail_len < MASK_LIMIT) begin
			tail_len++;
			if (c == CH_DOT) begin
				tail_dot = 1'b1;
			end else if (is_num(c)) begin
				v = pfx_val * 10 + int'(c - CH_ZERO);
				pfx_val = (v > PFX_SAT) ? PFX_SAT : v;
			end else begin
				pfx_bad = 1'b1;
			end
			quad_char(c, mask_acc, dot_bad);
		end
		if (fin) begin
			if (!seen_slash) begin
				quad_end(addr_acc, addr_bad);
				r.valid_res = !addr_bad;
				r.mask = '0;
			end else if (tail_dot) begin
				quad_end(mask_acc, dot_bad);
				r.valid_res = !(addr_bad || dot_bad);
				r.mask = mask_acc;
			end else begin
				if (pfx_val > PFX_TOP)
					pfx_bad = 1'b1;
				r.valid_res = !(addr_bad || pfx_bad);
				// A zero prefix means no mask bits at all, not a full shift.
				if (pfx_val == 0 || pfx_val > PFX_TOP)
					r.mask = '0;
				else
					r.mask = 32'hFFFF_FFFF << (PFX_TOP - pfx_val);
			end
			r.address = addr_acc;
			if (!r.valid_res) begin
				r.address = '0;
				r.mask = '0;
			end
			due_results.push_back(r);
			clear_parser();
		end
	endfunction

	function automatic logic sender_gap();
		case (flow)
			FLOW_SENDER_GAPS: return $urandom_range(99) < 62;
			FLOW_BOTH:        return $urandom_range(99) < 30;
			default:          return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_hold();
		case (flow)
			FLOW_RECEIVER_STALLS: return $urandom_range(99) < 62;
			FLOW_BOTH:            return $urandom_range(99) < 30;
			default:              return 1'b0;
		endcase
	endfunction

	// The driver presents a new word once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_taken) begin
				if (char_stream.size() != 0 && !sender_gap()) begin
					next_word = char_stream.pop_front();
					item_valid <= 1'b1;
					ch <= next_word.code;
					last <= next_word.final_char;
				end else begin
					item_valid <= 1'b0;
				end
			end
			res_stall <= receiver_hold();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			item_taken <= item_valid && !item_stall;
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					$error("result word with nothing expected: valid_res %0b address %h mask %h",
						valid_res, address, mask);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (valid_res !== want.valid_res) begin
						$error("valid_res: expected %0b, got %0b", want.valid_res, valid_res);
						mismatches++;
					end
					if (address !== want.address) begin
						$error("address: expected %h, got %h", want.address, address);
						mismatches++;
					end
					if (mask !== want.mask) begin
						$error("mask: expected %h, got %h", want.mask, mask);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall)
				parse_char(ch, last);
		end
	end

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			draft.push_back(s[i]);
	endfunction

	function automatic void commit_draft();
		char_word_t w;
		for (int i = 0; i < draft.size(); i++) begin
			w.code = draft[i];
			w.final_char = (i == draft.size() - 1);
			char_stream.push_back(w);
		end
		chars_queued += draft.size();
		draft.delete();
	endfunction

	function automatic void send_text(input string s);
		add_text(s);
		commit_draft();
	endfunction

	function automatic void add_octet();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 65)
			add_text($sformatf("%0d", $urandom_range(255)));
		else if (pick < 78)
			add_text($sformatf("%03d", $urandom_range(255)));
		else if (pick < 84)
			add_text("");
		else if (pick < 92)
			add_text($sformatf("%0d", $urandom_range(999, 256)));
		else
			add_text($sformatf("%04d", $urandom_range(9999)));
	endfunction

	function automatic logic [7:0] noise_char();
		string alphabet;
		alphabet = "0123456789./";
		if ($urandom_range(2) == 0)
			return 8'($urandom_range(255));
		return alphabet[$urandom_range(11)];
	endfunction

	function automatic void add_quad_mask();
		int unsigned p;
		logic [31:0] m;
		if ($urandom_range(1) == 0) begin
			p = $urandom_range(32);
			m = (p == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - p));
			add_text($sformatf("%0d.%0d.%0d.%0d", m[31:24], m[23:16], m[15:8], m[7:0]));
		end else begin
			for (int i = 0; i < 4; i++) begin
				if (i != 0)
					add_text(".");
				add_octet();
			end
		end
	endfunction

	function automatic void make_random_string();
		int unsigned pick, parts, n;
		pick = $urandom_range(99);
		if (pick < 10) begin
			n = $urandom_range(40, 1);
			repeat (n) draft.push_back(noise_char());
		end else begin
			parts = ($urandom_range(99) < 90) ? 4 : $urandom_range(5);
			for (int i = 0; i < parts; i++) begin
				if (i != 0)
					add_text(".");
				add_octet();
			end
			if ($urandom_range(99) < 5)
				add_text(".");
			pick = $urandom_range(99);
			if (pick < 30) begin
				add_text("");
			end else if (pick < 60) begin
				add_text("/");
				if ($urandom_range(99) < 90)
					add_text($sformatf("%0d", $urandom_range(40)));
				else
					add_text($sformatf("%05d", $urandom_range(99999)));
			end else if (pick < 63) begin
				add_text("/");
			end else if (pick < 88) begin
				add_text("/");
				add_quad_mask();
			end else begin
				// Long tails run past the point where mask characters are dropped.
				add_text("/");
				n = $urandom_range(45, 25);
				repeat (n) draft.push_back(noise_char());
			end
			if ($urandom_range(99) < 12 && draft.size() != 0) begin
				n = $urandom_range(draft.size() - 1);
				if ($urandom_range(1) == 0)
					draft[n] = noise_char();
				else
					draft.insert(n, noise_char());
			end
		end
		if (draft.size() == 0)
			draft.push_back(noise_char());
		commit_draft();
	endfunction

	task automatic drain();
		while (char_stream.size() != 0 || item_valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int phase_start;
		clear_parser();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_text("0.0.0.0");
		send_text("255.255.255.255");
		send_text("192.168.1.10/24");
		send_text("10.0.0.1/0");
		send_text("10.0.0.1/32");
		send_text("10.0.0.1/33");
		send_text("10.0.0.1/");
		send_text("10.0.0.1/255.255.0.0");
		send_text("....");
		send_text("1.2.3.4.");
		send_text("1.2.3.0255");
		send_text("1.2.3.0256");
		send_text("256.1.1.1");
		send_text("1.2.3.4.5");
		send_text("1..3");
		send_text("001.002.003.004/8");
		send_text("001.002.003.0004/8");
		send_text("001.002.003.0004");
		send_text("1.2.3.4/2/4");
		send_text("99999999.1.1.1");
		send_text("1.2.3.4/99999");
		send_text("1.2.3.4/1.2.3.4.5");
		send_text("/");
		// Thirty-one mask characters are taken; the dot after them is dropped.
		add_text("1.2.3.4/");
		repeat (29) add_text("0");
		send_text("24xyz.9");
		add_text("1.2");
		draft.push_back(8'h00);
		send_text(".3.4");
		add_text("1.2.3.4/");
		draft.push_back(8'hFF);
		commit_draft();
		drain();

		for (int round = 0; round < 2; round++) begin
			for (int k = 0; k < 4; k++) begin
				flow = flow_t'(k);
				phase_start = chars_queued;
				while (chars_queued - phase_start < CHARS_PER_PHASE)
					make_random_string();
				drain();
			end
		end

		flow = FLOW_FREE;
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
design/iamp_pkg.sv
design/iamp_parse.sv
design/ipv4_address_mask_parser_unit.sv
sim/ipv4_address_mask_parser_unit_test.sv
